[hw/rtl/fpsi_pkg.sv]
// ============================================================================
// FFT power spectrum integrator package
// Shared constants, types and the twiddle function.
// ============================================================================
package fpsi_pkg;

    localparam int FFT_POINTS = 1024;
    localparam int POS_W      = $clog2(FFT_POINTS);
    localparam int QUARTER    = FFT_POINTS / 4;
    localparam int SAMPLE_W   = 16;
    localparam int POWER_W    = 52;
    localparam int SUM_W      = 64;
    localparam int COUNT_W    = 13;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    // Configuration register indexes.
    localparam logic [0:0] REG_INTEGRATIONS = 1'b0;
    localparam logic [0:0] REG_REVERSE      = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       frame_end;
    } sample_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [POWER_W-1:0] power;
        logic               last;
    } bin_item_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_COLLECT,
        BK_DFT,
        BK_ROUND,
        BK_POWER,
        BK_ACCUM,
        BK_DIVIDE,
        BK_STORE
    } back_state_t;

    // Reference twiddle: Q30 Taylor series on the first quadrant, rounded to Q15.
    function automatic logic [31:0] make_twiddle(input logic [POS_W-1:0] m);
        logic [63:0] turn;
        logic [1:0]  quad;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] t;
        logic [63:0] sr;
        logic [63:0] cr;
        logic signed [15:0] sv;
        logic signed [15:0] cv;
        logic signed [15:0] c_o;
        logic signed [15:0] s_o;
        turn = ((64'(m) << 32) / 64'(FFT_POINTS)) & 64'hFFFF_FFFF;
        quad = turn[31:30];
        x    = ((turn & 64'h3FFF_FFFF) * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        ts   = 64'd1 << 30;
        tc   = 64'd1 << 30;
        for (int k = 8; k >= 1; k--) begin
            t  = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            ts = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
            t  = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
            tc = (t >= (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - t;
        end
        sr = (((ts * x) >> 30) + 64'd16384) >> 15;
        cr = (tc + 64'd16384) >> 15;
        sv = (sr > 64'd32767) ? 16'sd32767 : 16'(sr);
        cv = (cr > 64'd32767) ? 16'sd32767 : 16'(cr);
        case (quad)
            2'd0:    begin c_o = cv;  s_o = sv;  end
            2'd1:    begin c_o = -sv; s_o = cv;  end
            2'd2:    begin c_o = -cv; s_o = -sv; end
            default: begin c_o = sv;  s_o = -cv; end
        endcase
        return {c_o, s_o};
    endfunction

    // First-quadrant twiddles {cos, sin}, one 32-bit word per entry; the
    // other quadrants follow by swapping and negating.
    function automatic logic [QUARTER*32-1:0] build_tw_table();
        logic [QUARTER*32-1:0] tbl;
        tbl = '0;
        for (int i = 0; i < QUARTER; i++) begin
            tbl[i*32 +: 32] = make_twiddle(POS_W'(i));
        end
        return tbl;
    endfunction

    localparam logic [QUARTER*32-1:0] TW_TABLE = build_tw_table();

endpackage

[hw/rtl/fpsi_front.sv]
// ============================================================================
// FFT power spectrum integrator front end
// Accepts samples, tracks the fill position and marks each frame end.
// ============================================================================
module fpsi_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [fpsi_pkg::SAMPLE_W-1:0] in_re,
    input  logic signed [fpsi_pkg::SAMPLE_W-1:0] in_im,
    input  logic                          take,
    output fpsi_pkg::sample_item_t        item,
    output logic [fpsi_pkg::POS_W-1:0]    position
);
    import fpsi_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (in_valid && take)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        item.re        = in_re;
        item.im        = in_im;
        item.frame_end = (pos_reg == POS_W'(FFT_POINTS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign position = pos_reg;

endmodule

[hw/rtl/fpsi_queue.sv]
// ============================================================================
// FFT power spectrum integrator queue
// Short FIFO between the front end and the frame engine.
// ============================================================================
module fpsi_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fpsi_pkg::sample_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output fpsi_pkg::sample_item_t pop_item,
    output logic                   not_empty
);
    import fpsi_pkg::*;

    sample_item_t       slot_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg;
    logic [QPTR_W-1:0]  rd_reg;
    logic [QPTR_W:0]    cnt_reg;

    assign full      = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_item  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

[hw/rtl/fpsi_back.sv]
// ============================================================================
// FFT power spectrum integrator frame engine
// Stores frames, runs the DFT bin by bin, accumulates and averages power.
// ============================================================================
module fpsi_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  fpsi_pkg::sample_item_t q_item,
    output logic                   q_pop,
    input  logic [fpsi_pkg::COUNT_W-1:0] cfg_count,
    input  logic                   cfg_reverse,
    input  logic                   rd_en,
    input  logic [fpsi_pkg::POS_W-1:0] rd_pos,
    output logic [fpsi_pkg::POWER_W-1:0] rd_power,
    output logic                   publish,
    output logic                   busy
);
    import fpsi_pkg::*;

    logic [31:0]        frame_mem [FFT_POINTS];
    logic [SUM_W-1:0]   sum_mem   [FFT_POINTS];
    logic [POWER_W-1:0] spec_mem  [FFT_POINTS];

    back_state_t      state_reg, state_next;
    logic [POS_W-1:0] wpos_reg;
    logic [POS_W-1:0] k_reg;
    logic [POS_W:0]   n_reg;
    logic [POS_W-1:0] m_reg;
    logic [11:0]      summed_reg;
    logic             final_reg;
    logic [12:0]      eff_reg;
    logic signed [47:0] sre_reg, sim_reg;
    logic signed [31:0] pre_reg, pim_reg;
    logic [63:0]      pw_reg;
    logic [POS_W-1:0] idx_reg;
    logic [SUM_W-1:0] old_reg;
    logic [31:0]      frd_reg;
    logic [31:0]      tw_reg;
    logic             mac_valid_reg;
    logic             n_odd_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [6:0]       div_cnt_reg;
    logic [POS_W:0]   p_reg;
    logic             pub_reg;

    logic [31:0]        tw_base;
    logic signed [15:0] tw_c0, tw_s0;
    logic [31:0]        tw_word;

    // Twiddle from the quarter-wave table and the quadrant bits of m.
    always_comb
    begin
        tw_base = TW_TABLE[{m_reg[POS_W-3:0], 5'b00000} +: 32];
        tw_c0   = tw_base[31:16];
        tw_s0   = tw_base[15:0];
        case (m_reg[POS_W-1:POS_W-2])
            2'd0:    tw_word = {tw_c0, tw_s0};
            2'd1:    tw_word = {-tw_s0, tw_c0};
            2'd2:    tw_word = {-tw_c0, -tw_s0};
            default: tw_word = {tw_s0, -tw_c0};
        endcase
    end

    // Reads of the frame memory and twiddle table, registered.
    always_ff @(posedge clk)
    begin
        frd_reg   <= frame_mem[n_reg[POS_W-1:0]];
        tw_reg    <= tw_word;
        n_odd_reg <= n_reg[0];
        if (rd_en)
        begin
            rd_power <= spec_mem[rd_pos];
        end
        old_reg   <= sum_mem[idx_reg];
    end

    logic signed [15:0] xr, xi, tc, tsn;
    logic signed [47:0] term_re, term_im;
    always_comb
    begin
        xr  = frd_reg[15:0];
        xi  = frd_reg[31:16];
        tc  = tw_reg[31:16];
        tsn = tw_reg[15:0];
        if (n_odd_reg)
        begin
            xr = -xr;
            xi = -xi;
        end
        term_re = 48'(xr * tc) + 48'(xi * tsn);
        term_im = 48'(xi * tc) - 48'(xr * tsn);
        // negating -32768 wraps; correct with the true sign flip
        if (n_odd_reg && frd_reg[15:0] == 16'h8000)
        begin
            term_re = 48'(32'sd32768 * tc) + 48'(xi * tsn);
            term_im = 48'(xi * tc) - 48'(32'sd32768 * tsn);
        end
        if (n_odd_reg && frd_reg[31:16] == 16'h8000)
        begin
            term_re = 48'((n_odd_reg && frd_reg[15:0] == 16'h8000 ? 32'sd32768 : 32'(xr)) * tc)
                    + 48'(32'sd32768 * tsn);
            term_im = 48'(32'sd32768 * tc)
                    - 48'((n_odd_reg && frd_reg[15:0] == 16'h8000 ? 32'sd32768 : 32'(xr)) * tsn);
        end
    end

    logic signed [47:0] rre, rim;
    logic [SUM_W:0]     acc_sum;
    logic [SUM_W:0]     trial;
    always_comb
    begin
        rre     = (sre_reg + 48'sd16384) >>> 15;
        rim     = (sim_reg + 48'sd16384) >>> 15;
        acc_sum = {1'b0, old_reg} + {1'b0, pw_reg};
        trial   = {rem_reg[SUM_W-1:0], quo_reg[SUM_W-1]} - (SUM_W+1)'(eff_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_CLEAR:  if (p_reg == (POS_W+1)'(FFT_POINTS - 1)) state_next = BK_COLLECT;
            BK_COLLECT: if (q_valid)
            begin
                q_pop = 1'b1;
                if (q_item.frame_end)
                begin
                    state_next = BK_DFT;
                end
            end
            BK_DFT:    if (n_reg == (POS_W+1)'(FFT_POINTS + 1)) state_next = BK_ROUND;
            BK_ROUND:  state_next = BK_POWER;
            BK_POWER:  state_next = BK_ACCUM;
            BK_ACCUM:
            begin
                if (k_reg == POS_W'(FFT_POINTS - 1))
                begin
                    state_next = final_reg ? BK_DIVIDE : BK_COLLECT;
                end
                else
                begin
                    state_next = BK_DFT;
                end
            end
            BK_DIVIDE: if (div_cnt_reg == 7'd64) state_next = BK_STORE;
            BK_STORE:  state_next = (p_reg == (POS_W+1)'(FFT_POINTS - 1)) ? BK_COLLECT : BK_DIVIDE;
            default:   state_next = BK_COLLECT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_COLLECT && q_valid)
        begin
            frame_mem[wpos_reg] <= {q_item.im, q_item.re};
        end
        if (state_reg == BK_ACCUM)
        begin
            sum_mem[idx_reg] <= acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
        end
        else if (state_reg == BK_STORE || state_reg == BK_CLEAR)
        begin
            sum_mem[p_reg[POS_W-1:0]] <= '0;
        end
        if (state_reg == BK_STORE)
        begin
            spec_mem[p_reg[POS_W-1:0]] <= (quo_reg > 64'((64'd1 << POWER_W) - 1))
                ? {POWER_W{1'b1}} : quo_reg[POWER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            wpos_reg      <= '0;
            k_reg         <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            summed_reg    <= '0;
            final_reg     <= 1'b0;
            eff_reg       <= 13'd1;
            sre_reg       <= '0;
            sim_reg       <= '0;
            pre_reg       <= '0;
            pim_reg       <= '0;
            pw_reg        <= '0;
            idx_reg       <= '0;
            mac_valid_reg <= 1'b0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            div_cnt_reg   <= '0;
            p_reg         <= '0;
            pub_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pub_reg   <= 1'b0;
            unique case (state_reg)
                BK_CLEAR:
                begin
                    p_reg <= p_reg + (POS_W+1)'(1);
                end
                BK_COLLECT:
                begin
                    if (q_valid)
                    begin
                        wpos_reg <= wpos_reg + POS_W'(1);
                        if (q_item.frame_end)
                        begin
                            k_reg   <= '0;
                            n_reg   <= '0;
                            m_reg   <= '0;
                            sre_reg <= '0;
                            sim_reg <= '0;
                            mac_valid_reg <= 1'b0;
                            if (cfg_count == '0)
                                eff_reg <= 13'd1;
                            else if (cfg_count > 13'd4096)
                                eff_reg <= 13'd4096;
                            else
                                eff_reg <= cfg_count;
                            final_reg <= ({1'b0, summed_reg} + 13'd1 >= cfg_count)
                                || (cfg_count > 13'd4096 && summed_reg == 12'd4095);
                        end
                    end
                end
                BK_DFT:
                begin
                    if (mac_valid_reg)
                    begin
                        sre_reg <= sre_reg + term_re;
                        sim_reg <= sim_reg + term_im;
                    end
                    mac_valid_reg <= (n_reg < (POS_W+1)'(FFT_POINTS));
                    n_reg <= n_reg + (POS_W+1)'(1);
                    m_reg <= m_reg + k_reg;
                    idx_reg <= cfg_reverse ? POS_W'(FFT_POINTS - 1) - k_reg : k_reg;
                end
                BK_ROUND:
                begin
                    pre_reg <= 32'(rre[31:0]);
                    pim_reg <= 32'(rim[31:0]);
                end
                BK_POWER:
                begin
                    pw_reg <= 64'(pre_reg * pre_reg) + 64'(pim_reg * pim_reg);
                end
                BK_ACCUM:
                begin
                    k_reg   <= k_reg + POS_W'(1);
                    n_reg   <= '0;
                    m_reg   <= '0;
                    sre_reg <= '0;
                    sim_reg <= '0;
                    mac_valid_reg <= 1'b0;
                    if (k_reg == POS_W'(FFT_POINTS - 1))
                    begin
                        if (final_reg)
                        begin
                            summed_reg  <= '0;
                            p_reg       <= '0;
                            div_cnt_reg <= '0;
                        end
                        else
                        begin
                            summed_reg <= summed_reg + 12'd1;
                        end
                    end
                end
                BK_DIVIDE:
                begin
                    if (div_cnt_reg == 7'd0)
                    begin
                        rem_reg <= '0;
                        quo_reg <= sum_mem[p_reg[POS_W-1:0]];
                    end
                    else if (div_cnt_reg <= 7'd64)
                    begin
                        if (!trial[SUM_W])
                        begin
                            rem_reg <= trial[SUM_W-1:0];
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                    end
                    div_cnt_reg <= div_cnt_reg + 7'd1;
                end
                BK_STORE:
                begin
                    p_reg       <= p_reg + (POS_W+1)'(1);
                    div_cnt_reg <= '0;
                    if (p_reg == (POS_W+1)'(FFT_POINTS - 1))
                    begin
                        pub_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign publish = pub_reg;
    assign busy    = (state_reg != BK_COLLECT);

endmodule

[hw/rtl/fft_power_spectrum_integrator.sv]
// ============================================================================
// FFT power spectrum integrator
// Frames complex samples, runs a DFT per frame, integrates and averages power.
// ============================================================================
// Usage:
// Samples enter on the sample channel (in_valid / in_stall). Registers are
// written on cfg_valid / cfg_ready, which is always ready; writes are meant
// for idle periods. Each accepted transaction stores one sample at the fill
// position and passes through a four-entry queue to the frame engine, so the
// samples of one frame flow at one per cycle while neither the queue nor the
// output side stalls. At the last sample of a frame the engine computes one
// bin at a time with a single complex multiply-accumulate, and averages
// every bin when the frame completes a spectrum. The first sample of the
// next frame is stalled until the engine is idle again, so every frame
// boundary costs that whole computation.
// While a finished spectrum is pending, each accepted sample produces one
// output transaction (out_valid / out_stall) in the following cycle,
// carrying the bin at the sample's fill position from an output register. A
// stall on the output side holds the input side too. Reset clears all
// control state; the engine then zeroes the power accumulators while the
// first sample waits.
module fft_power_spectrum_integrator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [fpsi_pkg::COUNT_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [15:0]            sample_re,
    input  logic signed [15:0]            sample_im,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [9:0]                    bin_position,
    output logic [51:0]                   bin_power,
    output logic                          last_bin
);
    import fpsi_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic               reverse_reg;
    logic               pending_reg;
    logic               next_ready_reg;
    logic               out_valid_reg;
    logic [POS_W-1:0]   out_pos_reg;
    logic               out_last_reg;
    logic               full;
    logic               busy;
    logic               hold_first;
    logic               take;
    logic               accept;
    logic               publish;
    logic               q_valid;
    logic               q_pop;
    sample_item_t       f_item;
    sample_item_t       q_item;
    logic [POS_W-1:0]   position;
    logic [POWER_W-1:0] rd_power;

    // The first sample of a frame waits until the previous frame has been
    // fully processed, so a spectrum it completes is ready for readout.
    assign hold_first = (position == '0) && (q_valid || busy);
    assign cfg_ready  = 1'b1;
    assign take       = !full && !hold_first && !(out_valid_reg && out_stall);
    assign in_stall   = !take;
    assign accept     = in_valid && take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= COUNT_W'(1);
            reverse_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INTEGRATIONS: count_reg   <= cfg_data;
                REG_REVERSE:      reverse_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A spectrum becomes readable at the next frame start; a newer one waits
    // until the last bin of the current readout has gone out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            next_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (publish)
            begin
                next_ready_reg <= 1'b1;
            end
            if (accept && position == '0 && (next_ready_reg || publish))
            begin
                pending_reg    <= 1'b1;
                next_ready_reg <= 1'b0;
            end
            else if (accept && pending_reg && f_item.frame_end)
            begin
                pending_reg <= 1'b0;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && (pending_reg || (position == '0 && (next_ready_reg || publish))))
            begin
                out_valid_reg <= 1'b1;
                out_pos_reg   <= position;
                out_last_reg  <= f_item.frame_end;
            end
        end
    end

    fpsi_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_re    (sample_re),
        .in_im    (sample_im),
        .take     (take),
        .item     (f_item),
        .position (position)
    );

    fpsi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (f_item),
        .full      (full),
        .pop       (q_pop),
        .pop_item  (q_item),
        .not_empty (q_valid)
    );

    fpsi_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_count   (count_reg),
        .cfg_reverse (reverse_reg),
        .rd_en       (accept),
        .rd_pos      (position),
        .rd_power    (rd_power),
        .publish     (publish),
        .busy        (busy)
    );

    assign out_valid    = out_valid_reg;
    assign bin_position = 10'(out_pos_reg);
    assign bin_power    = rd_power;
    assign last_bin     = out_last_reg;

endmodule

[tb/sv/tb_fft_power_spectrum_integrator.sv]
`timescale 1ns / 1ps
// ============================================================================
// FFT power spectrum integrator testbench
// Streams three frames of complex samples into the integrator, predicts every
// averaged bin with a bit-exact DFT and power accumulator of its own, and
// compares each output transaction field by field against that prediction.
// ============================================================================
module tb_fft_power_spectrum_integrator;

    import fpsi_pkg::*;

    // FRAME_CYCLES covers the frame engine's DFT of one frame plus the
    // averaging of every bin. A quarter more, DRAIN_CYCLES, is what we wait
    // out before touching the registers; the watchdog allows WATCHDOG_MAX.
    localparam longint FRAME_CYCLES  = longint'(FFT_POINTS) * (FFT_POINTS + 71);
    localparam longint DRAIN_CYCLES  = FRAME_CYCLES + FRAME_CYCLES / 4;
    localparam longint WATCHDOG_MAX  = 4 * FRAME_CYCLES;
    localparam longint unsigned Q30  = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned POWER_SAT   = (64'd1 << 52) - 1;
    localparam longint unsigned SUM_SAT     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [0:0]           cfg_index;
    logic [COUNT_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [15:0]   sample_re;
    logic signed [15:0]   sample_im;
    logic                 out_valid;
    logic                 out_stall;
    logic [9:0]           bin_position;
    logic [51:0]          bin_power;
    logic                 last_bin;

    fft_power_spectrum_integrator i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bin_position (bin_position),
        .bin_power    (bin_power),
        .last_bin     (last_bin)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Spectrum predictor state. It mirrors the block: the frame being filled,
    // one saturating 64-bit sum per bin, the finished spectrum, and the
    // counters that decide when a spectrum is complete and being read out.
    // ------------------------------------------------------------------------
    int                 tw_cos [FFT_POINTS];
    int                 tw_sin [FFT_POINTS];
    int                 frame_re [FFT_POINTS];
    int                 frame_im [FFT_POINTS];
    longint unsigned    power_acc [FFT_POINTS];
    longint unsigned    spectrum [FFT_POINTS];
    int                 fill_pos;
    int                 frames_done;
    bit                 spectrum_ready;
    logic [COUNT_W-1:0] integ_count;
    bit                 reverse_order;

    bin_item_t          pending_bins [$];
    int                 errors;
    int                 bins_seen;
    int                 idle_mode;
    longint             quiet_cycles;

    // Twiddles in Q1.15, from Q30 Taylor series on the first quadrant, rounded
    // half up, with +1.0 clipped to 32767.
    function automatic void build_twiddles();
        longint unsigned turn, x, x2, ts, tc, t, sr, cr;
        int sv, cv;
        for (int m = 0; m < FFT_POINTS; m++)
        begin
            turn = ((longint'(m) << 32) / FFT_POINTS) & 64'hFFFF_FFFF;
            x    = ((turn & (Q30 - 1)) * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            ts   = Q30;
            tc   = Q30;
            for (int k = 8; k >= 1; k--)
            begin
                t  = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                ts = (t >= Q30) ? 64'd0 : Q30 - t;
                t  = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                tc = (t >= Q30) ? 64'd0 : Q30 - t;
            end
            sr = (((ts * x) >> 30) + 64'd16384) >> 15;
            cr = (tc + 64'd16384) >> 15;
            sv = (sr > 32767) ? 32767 : int'(sr);
            cv = (cr > 32767) ? 32767 : int'(cr);
            case (turn[31:30])
                2'd0:
                begin
                    tw_cos[m] = cv;
                    tw_sin[m] = sv;
                end
                2'd1:
                begin
                    tw_cos[m] = -sv;
                    tw_sin[m] = cv;
                end
                2'd2:
                begin
                    tw_cos[m] = -cv;
                    tw_sin[m] = -sv;
                end
                default:
                begin
                    tw_cos[m] = sv;
                    tw_sin[m] = -cv;
                end
            endcase
        end
    endfunction

    // Runs the DFT over a full frame, adds each bin's power into its sum and
    // finishes a spectrum when enough frames have been integrated.
    function automatic void integrate_frame();
        longint          acc_re, acc_im, xr, xi;
        longint unsigned pw, avg;
        int              m, slot, eff;
        eff = (integ_count == 0) ? 1 : (integ_count > 4096) ? 4096 : int'(integ_count);
        for (int k = 0; k < FFT_POINTS; k++)
        begin
            acc_re = 0;
            acc_im = 0;
            m      = 0;
            for (int n = 0; n < FFT_POINTS; n++)
            begin
                xr = frame_re[n];
                xi = frame_im[n];
                // Negating odd samples shifts DC to the centre bin.
                if (n % 2 == 1)
                begin
                    xr = -xr;
                    xi = -xi;
                end
                acc_re += xr * tw_cos[m] + xi * tw_sin[m];
                acc_im += xi * tw_cos[m] - xr * tw_sin[m];
                m += k;
                if (m >= FFT_POINTS)
                    m -= FFT_POINTS;
            end
            acc_re = (acc_re + 16384) >>> 15;
            acc_im = (acc_im + 16384) >>> 15;
            pw     = longint'(acc_re * acc_re) + longint'(acc_im * acc_im);
            slot   = reverse_order ? FFT_POINTS - 1 - k : k;
            power_acc[slot] = (power_acc[slot] > SUM_SAT - pw) ? SUM_SAT
                                                               : power_acc[slot] + pw;
        end
        if (frames_done + 1 >= eff)
        begin
            for (int p = 0; p < FFT_POINTS; p++)
            begin
                avg          = power_acc[p] / longint'(eff);
                spectrum[p]  = (avg > POWER_SAT) ? POWER_SAT : avg;
                power_acc[p] = 0;
            end
            frames_done    = 0;
            spectrum_ready = 1'b1;
        end
        else
            frames_done++;
    endfunction

    // One accepted sample: read out the pending bin at the fill position, if
    // any, then store the sample and close the frame when it is full.
    function automatic bit predict_sample(input logic signed [15:0] re,
                                          input logic signed [15:0] im,
                                          output bin_item_t bin);
        bit got;
        got = 1'b0;
        bin = '0;
        if (spectrum_ready)
        begin
            bin.position = POS_W'(fill_pos);
            bin.power    = spectrum[fill_pos][51:0];
            bin.last     = (fill_pos == FFT_POINTS - 1);
            got          = 1'b1;
            if (fill_pos == FFT_POINTS - 1)
                spectrum_ready = 1'b0;
        end
        frame_re[fill_pos] = re;
        frame_im[fill_pos] = im;
        fill_pos++;
        if (fill_pos >= FFT_POINTS)
        begin
            fill_pos = 0;
            integrate_frame();
        end
        return got;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Output checker and watchdog. Both sample at the rising edge, where the
    // values seen are those that were stable across the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        bin_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            bins_seen++;
            if (pending_bins.size() == 0)
            begin
                $display("%0t: bin transaction at position %0d with none expected",
                         $realtime, bin_position);
                errors++;
            end
            else
            begin
                want = pending_bins.pop_front();
                if (bin_position != want.position)
                    report_mismatch("bin_position", bin_position, want.position);
                if (bin_power != want.power)
                    report_mismatch("bin_power", bin_power, want.power);
                if (last_bin != want.last)
                    report_mismatch("last_bin", last_bin, want.last);
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("%0t: watchdog expired with %0d bins outstanding",
                     $realtime, pending_bins.size());
            $display("tb_fft_power_spectrum_integrator NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Stalls at random by the current idle mode, and once holds off
    // for a long stretch so that the output register and the input side back
    // up while the sender keeps offering samples.
    // ------------------------------------------------------------------------
    initial
    begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && bins_seen == 100)
            begin
                held      = 1'b1;
                out_stall <= 1'b1;
                repeat (500) @(negedge clk);
            end
            case (idle_mode)
                0:       out_stall <= ($urandom_range(99, 0) < 75);
                1:       out_stall <= ($urandom_range(99, 0) < 11);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------
    task automatic write_register(input logic [0:0] index, input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_INTEGRATIONS)
            integ_count = value;
        else
            reverse_order = value[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one sample, with a random gap first, and returns once the
    // transaction has been accepted. The idle mode follows the fill position,
    // so each part of a frame gets its own kind of gap, and the last part none.
    task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                               output bit got);
        bin_item_t bin;
        int gap_pct;
        idle_mode = (fill_pos < 340) ? 0 : (fill_pos < 680) ? 1 : 2;
        gap_pct   = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 75 : 0;
        if ($urandom_range(99, 0) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99, 0) < gap_pct);
        end
        in_valid  <= 1'b1;
        sample_re <= re;
        sample_im <= im;
        do
            @(posedge clk);
        while (in_stall);
        got = predict_sample(re, im, bin);
        if (got)
            pending_bins.push_back(bin);
        @(negedge clk);
    endtask

    task automatic wait_for_bins();
        if (pending_bins.size() != 0)
        begin
            in_valid <= 1'b0;
            while (pending_bins.size() != 0)
                @(negedge clk);
        end
    endtask

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        bit                 has_bin;
    } stim_row_t;

    // Directed opening of the first frame: extremes and alternating bit
    // patterns. Nothing is pending after reset, so no row yields a bin.
    stim_row_t directed_rows [16] = '{
        '{16'sd0,      16'sd0,      1'b0},
        '{16'sd32767,  16'sd32767,  1'b0},
        '{-16'sd32768, -16'sd32768, 1'b0},
        '{16'sd32767,  -16'sd32768, 1'b0},
        '{-16'sd32768, 16'sd32767,  1'b0},
        '{-16'sd1,     -16'sd1,     1'b0},
        '{16'sd1,      -16'sd1,     1'b0},
        '{16'sd0,      -16'sd32768, 1'b0},
        '{-16'sd32768, 16'sd0,      1'b0},
        '{16'h5555,    16'hAAAA,    1'b0},
        '{16'hAAAA,    16'h5555,    1'b0},
        '{16'sd1,      16'sd0,      1'b0},
        '{16'sd0,      16'sd1,      1'b0},
        '{-16'sd2,     16'sd32766,  1'b0},
        '{16'sd32767,  16'sd0,      1'b0},
        '{16'sd0,      16'sd32767,  1'b0}
    };

    initial
    begin
        bit got;
        int sent;
        errors         = 0;
        bins_seen      = 0;
        idle_mode      = 2;
        quiet_cycles   = 0;
        fill_pos       = 0;
        frames_done    = 0;
        spectrum_ready = 1'b0;
        integ_count    = 1;
        reverse_order  = 1'b0;
        for (int p = 0; p < FFT_POINTS; p++)
        begin
            power_acc[p] = 0;
            spectrum[p]  = 0;
        end
        build_twiddles();

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_INTEGRATIONS;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample_re = '0;
        sample_im = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // First frame: the largest count the field can hold, which the block
        // clips to 4096, so this frame only starts an integration.
        write_register(REG_REVERSE, 1'b0);
        write_register(REG_INTEGRATIONS, '1);
        sent = 0;
        foreach (directed_rows[i])
        begin
            send_sample(directed_rows[i].re, directed_rows[i].im, got);
            if (got != directed_rows[i].has_bin)
                report_mismatch("directed bin presence", got, directed_rows[i].has_bin);
            sent++;
        end
        while (sent < FFT_POINTS)
        begin
            send_sample(16'($urandom), 16'($urandom), got);
            sent++;
        end

        // Let the engine finish the frame, then lower the count mid
        // integration: zero acts as one, so the next frame end completes the
        // spectrum. Bin order is reversed from here on.
        in_valid <= 1'b0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        write_register(REG_INTEGRATIONS, '0);
        write_register(REG_REVERSE, 1'b1);

        // Second frame: mostly a full-scale constant, which lands in the
        // centre bin, mixed with random samples.
        for (int n = 0; n < FFT_POINTS; n++)
        begin
            if ($urandom_range(2, 0) != 0)
                send_sample(-16'sd32768, -16'sd32768, got);
            else
                send_sample(16'($urandom), 16'($urandom), got);
        end

        // Third frame reads the finished spectrum out, one bin per sample.
        // Part way through, the sender waits until every bin so far is back.
        for (int n = 0; n < FFT_POINTS; n++)
        begin
            if (n == 300)
                wait_for_bins();
            send_sample(16'($urandom), 16'($urandom), got);
        end
        in_valid <= 1'b0;

        while (pending_bins.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("tb_fft_power_spectrum_integrator OK");
        else
            $display("tb_fft_power_spectrum_integrator NOT OK");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/fpsi_pkg.sv
hw/rtl/fpsi_front.sv
hw/rtl/fpsi_queue.sv
hw/rtl/fpsi_back.sv
hw/rtl/fft_power_spectrum_integrator.sv
tb/sv/tb_fft_power_spectrum_integrator.sv
